// ===== sv/nsf_pkg.sv =====
package nsf_pkg;

    localparam int MAX_LEN = 128;
    localparam int LEN_CAP = (MAX_LEN < 255) ? MAX_LEN + 1 : 255;
    localparam logic [7:0] MAX_LEN_B = 8'(MAX_LEN);
    localparam logic [7:0] LEN_CAP_B = 8'(LEN_CAP);
    localparam logic [7:0] MIN_LEN_B = 8'd5;

    localparam int NUM_TYPES = 8;
    localparam logic [2:0] TYPE_LEN = 3'd5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [2:0] ST_ACCEPT   = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_MALFORM  = 3'd2;
    localparam logic [2:0] ST_NODOLLAR = 3'd3;
    localparam logic [2:0] ST_OVERLONG = 3'd4;

    localparam logic [3:0] TYPE_OTHER = 4'd8;

    localparam logic [1:0] PH_EMPTY  = 2'd0;
    localparam logic [1:0] PH_DOLLAR = 2'd1;
    localparam logic [1:0] PH_OTHER  = 2'd2;

    localparam logic [1:0] HX_LEAD  = 2'd0;
    localparam logic [1:0] HX_DIGIT = 2'd1;
    localparam logic [1:0] HX_TRAIL = 2'd2;
    localparam logic [1:0] HX_BAD   = 2'd3;

    localparam logic [2:0] TCI_LONG   = 3'd6;
    localparam logic [2:0] TCI_CLOSED = 3'd7;

    localparam logic [8:0] HEX_SAT = 9'd256;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] xsum;
        logic [7:0] count;
        logic [1:0] stars;
        logic [8:0] hex;
        logic [1:0] hex_st;
        logic [7:0] cand;
        logic [2:0] tci;
    } nsf_state_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] message_type;
        logic [7:0] computed_checksum;
        logic [7:0] sentence_length;
    } nsf_result_t;

    function automatic nsf_state_t clear_state();
        nsf_state_t s;
        s.phase  = PH_EMPTY;
        s.xsum   = 8'd0;
        s.count  = 8'd0;
        s.stars  = 2'd0;
        s.hex    = 9'd0;
        s.hex_st = HX_LEAD;
        s.cand   = 8'hFF;
        s.tci    = 3'd0;
        return s;
    endfunction

    // Character idx of known sentence type k
    function automatic logic [7:0] type_char(input logic [2:0] k, input logic [2:0] idx);
        logic [39:0] name;
        case (k)
            3'd0:    name = "GPGGA";
            3'd1:    name = "GPRMC";
            3'd2:    name = "PFLAA";
            3'd3:    name = "PFLAE";
            3'd4:    name = "PFLAS";
            3'd5:    name = "PFLAU";
            3'd6:    name = "PFLAV";
            default: name = "PGRMZ";
        endcase
        case (idx)
            3'd0:    return name[39:32];
            3'd1:    return name[31:24];
            3'd2:    return name[23:16];
            3'd3:    return name[15:8];
            3'd4:    return name[7:0];
            default: return 8'h00;
        endcase
    endfunction

endpackage

// ===== sv/nsf_in_if.sv =====
interface nsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ===== sv/nsf_out_if.sv =====
interface nsf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] message_type;
    logic [7:0] computed_checksum;
    logic [7:0] sentence_length;

    modport source (output valid, output status, output message_type,
                    output computed_checksum, output sentence_length, input ready);
    modport sink (input valid, input status, input message_type,
                  input computed_checksum, input sentence_length, output ready);
endinterface

// ===== sv/nsf_step.sv =====
module nsf_step (
    input  nsf_pkg::nsf_state_t  cur,
    input  logic [7:0]           data_byte,
    output nsf_pkg::nsf_state_t  nxt,
    output logic                 emit,
    output nsf_pkg::nsf_result_t result
);
    import nsf_pkg::*;

    always_comb
    begin
        logic [7:0]  c;
        logic [7:0]  keep;
        logic [3:0]  digit;
        logic        is_digit;
        logic        is_space;
        logic [12:0] hex_wide;
        logic [8:0]  eff;
        logic [3:0]  tcode;

        c        = data_byte;
        nxt      = cur;
        emit     = 1'b0;
        result   = '0;
        keep     = 8'd0;
        hex_wide = 13'd0;
        eff      = 9'd0;
        tcode    = TYPE_OTHER;

        is_space = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
        is_digit = 1'b1;
        digit    = 4'd0;
        if (c inside {[8'h30:8'h39]})
            digit = 4'(c - 8'h30);
        else if (c inside {[8'h41:8'h46]})
            digit = 4'(c - 8'h37);
        else if (c inside {[8'h61:8'h66]})
            digit = 4'(c - 8'h57);
        else
            is_digit = 1'b0;

        if (cur.count == 8'd0)
        begin
            nxt       = clear_state();
            nxt.phase = (c == CH_DOLLAR) ? PH_DOLLAR : PH_OTHER;
            nxt.count = 8'd1;
        end
        else if (c == CH_DOLLAR)
        begin
            // Close the open buffer with its error status and restart on this dollar
            emit                     = 1'b1;
            result.message_type      = TYPE_OTHER;
            result.computed_checksum = cur.xsum;
            result.sentence_length   = cur.count;
            if (cur.phase != PH_DOLLAR)
                result.status = ST_NODOLLAR;
            else if (cur.count > MAX_LEN_B)
                result.status = ST_OVERLONG;
            else if (cur.count < MIN_LEN_B || cur.stars != 2'd1)
                result.status = ST_MALFORM;
            else
                result.status = ST_CHECKSUM;
            nxt       = clear_state();
            nxt.phase = PH_DOLLAR;
            nxt.count = 8'd1;
        end
        else
        begin
            if (cur.count < LEN_CAP_B)
                nxt.count = cur.count + 8'd1;

            if (cur.stars == 2'd0)
            begin
                if (c == CH_STAR)
                begin
                    nxt.stars = 2'd1;
                    if (cur.tci != TCI_CLOSED)
                    begin
                        if (cur.tci != TYPE_LEN)
                            nxt.cand = 8'd0;
                        nxt.tci = TCI_CLOSED;
                    end
                end
                else
                begin
                    nxt.xsum = cur.xsum ^ c;
                    if (cur.tci != TCI_CLOSED)
                    begin
                        if (c == CH_COMMA)
                        begin
                            if (cur.tci != TYPE_LEN)
                                nxt.cand = 8'd0;
                            nxt.tci = TCI_CLOSED;
                        end
                        else if (cur.tci < TYPE_LEN)
                        begin
                            for (int k = 0; k < NUM_TYPES; k++)
                                keep[k] = (type_char(3'(k), cur.tci) == c);
                            nxt.cand = cur.cand & keep;
                            nxt.tci  = cur.tci + 3'd1;
                        end
                        else
                        begin
                            nxt.cand = 8'd0;
                            nxt.tci  = TCI_LONG;
                        end
                    end
                end
            end
            else if (c == CH_STAR)
            begin
                if (cur.stars != 2'd3)
                    nxt.stars = cur.stars + 2'd1;
            end
            else if (cur.stars == 2'd1 && cur.hex_st != HX_BAD)
            begin
                if (is_space)
                begin
                    if (cur.hex_st == HX_DIGIT)
                        nxt.hex_st = HX_TRAIL;
                end
                else if (is_digit && (cur.hex_st == HX_LEAD || cur.hex_st == HX_DIGIT))
                begin
                    nxt.hex_st = HX_DIGIT;
                    hex_wide   = {cur.hex, 4'd0} + {9'd0, digit};
                    nxt.hex    = (hex_wide > {4'd0, HEX_SAT}) ? HEX_SAT : hex_wide[8:0];
                end
                else
                    nxt.hex_st = HX_BAD;
            end

            eff = (nxt.hex_st == HX_BAD) ? 9'd0 : nxt.hex;

            for (int k = NUM_TYPES - 1; k >= 0; k--)
                if (nxt.cand[k])
                    tcode = 4'(k);
            if (nxt.tci != TCI_CLOSED)
                tcode = TYPE_OTHER;

            if (nxt.phase == PH_DOLLAR && nxt.count >= MIN_LEN_B &&
                nxt.count <= MAX_LEN_B && nxt.stars == 2'd1 && eff == {1'b0, nxt.xsum})
            begin
                emit                     = 1'b1;
                result.status            = ST_ACCEPT;
                result.message_type      = tcode;
                result.computed_checksum = nxt.xsum;
                result.sentence_length   = nxt.count;
                nxt                      = clear_state();
            end
        end
    end

endmodule

// ===== sv/nmea_sentence_framer_unit.sv =====
// Checks NMEA sentences of the form $body*hex, one received byte per clock. A
// byte is taken into an input register and, once the output register has
// room, updates the framing state in a single pass; a byte that completes a
// valid sentence, or a '$' that closes an open buffer, loads one result into
// the output register. The sustained rate is one byte per cycle; the input
// stalls only while the output register holds a result that is not yet taken.
module nmea_sentence_framer_unit (
    input  logic             clk,
    input  logic             rst_n,
    nsf_in_if.sink           rx,
    nsf_out_if.source        res
);
    import nsf_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    nsf_state_t  state_reg;
    nsf_state_t  state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    nsf_result_t out_reg;
    nsf_result_t step_result;
    logic        step_emit;
    logic        advance;

    nsf_step u_step (
        .cur       (state_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .emit      (step_emit),
        .result    (step_result)
    );

    // Process the held byte once the output register has room
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (rx.valid && rx.ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance && step_emit)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= clear_state();
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.data_byte;
        if (advance && step_emit)
            out_reg <= step_result;
    end

    assign res.valid             = out_valid_reg;
    assign res.status            = out_reg.status;
    assign res.message_type      = out_reg.message_type;
    assign res.computed_checksum = out_reg.computed_checksum;
    assign res.sentence_length   = out_reg.sentence_length;

    a_err_type_other: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status != ST_ACCEPT) |-> (res.message_type == TYPE_OTHER))
        else $error("error status with a known message type");

    a_accept_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_ACCEPT) |->
        (res.sentence_length >= MIN_LEN_B && res.sentence_length <= MAX_LEN_B))
        else $error("accepted sentence with bad length");

    a_hex_before_star: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.stars == 2'd0) |-> (state_reg.hex == 9'd0 && state_reg.hex_st == HX_LEAD))
        else $error("hex field parsed before star");

    a_empty_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.count == 8'd0) == (state_reg.phase == PH_EMPTY))
        else $error("buffer phase disagrees with length");

endmodule

// ===== tb/tb_nmea_sentence_framer_unit.sv =====
`timescale 1ns / 100ps

module tb_nmea_sentence_framer_unit;
    import nsf_pkg::*;

    typedef enum logic [3:0] {
        MT_GPGGA, MT_GPRMC, MT_PFLAA, MT_PFLAE, MT_PFLAS, MT_PFLAU, MT_PFLAV, MT_PGRMZ
    } msg_kind_t;

    localparam logic [39:0] SENTENCE_IDS [8] = '{
        "GPGGA", "GPRMC", "PFLAA", "PFLAE", "PFLAS", "PFLAU", "PFLAV", "PGRMZ"
    };

    typedef struct {
        logic [1:0] lead;
        logic [7:0] parity;
        logic [7:0] length;
        logic [1:0] stars;
        logic [8:0] hexval;
        logic [1:0] hexmode;
        logic [7:0] types;
        logic [2:0] tpos;
    } framer_t;

    typedef struct {
        string       text;
        bit          pinned;
        nsf_result_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    nsf_in_if  rx_if ();
    nsf_out_if res_if ();

    nmea_sentence_framer_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    framer_t     fr;
    nsf_result_t pending[$];
    script_row_t script[$];
    logic [7:0]  burst[$];
    int          sent_bytes = 0;
    int          fault_count = 0;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;

    always #4 clk = ~clk;

    initial begin
        #2_000_000;
        $display("nmea_sentence_framer_unit: mismatch");
        $finish;
    end

    function automatic framer_t empty_framer();
        framer_t f;
        f.lead    = PH_EMPTY;
        f.parity  = 8'h00;
        f.length  = 8'd0;
        f.stars   = 2'd0;
        f.hexval  = 9'd0;
        f.hexmode = HX_LEAD;
        f.types   = 8'hFF;
        f.tpos    = 3'd0;
        return f;
    endfunction

    task automatic close_type();
        if (fr.tpos == TCI_CLOSED)
            return;
        if (fr.tpos != TYPE_LEN)
            fr.types = 8'h00;
        fr.tpos = TCI_CLOSED;
    endtask

    // Advance the framer by one byte; got is set when the byte closes or accepts a sentence
    task automatic frame_byte(input logic [7:0] c, output bit got, output nsf_result_t r);
        int         d;
        int         v;
        logic [7:0] keep;
        got = 1'b0;
        r   = '0;
        if (fr.length == 8'd0) begin
            fr        = empty_framer();
            fr.lead   = (c == CH_DOLLAR) ? PH_DOLLAR : PH_OTHER;
            fr.length = 8'd1;
            return;
        end
        if (c == CH_DOLLAR) begin
            if (fr.lead != PH_DOLLAR)
                r.status = ST_NODOLLAR;
            else if (fr.length > MAX_LEN_B)
                r.status = ST_OVERLONG;
            else if (fr.length < MIN_LEN_B || fr.stars != 2'd1)
                r.status = ST_MALFORM;
            else
                r.status = ST_CHECKSUM;
            r.message_type      = TYPE_OTHER;
            r.computed_checksum = fr.parity;
            r.sentence_length   = fr.length;
            got       = 1'b1;
            fr        = empty_framer();
            fr.lead   = PH_DOLLAR;
            fr.length = 8'd1;
            return;
        end
        if (fr.length < LEN_CAP_B)
            fr.length = fr.length + 8'd1;
        if (fr.stars == 2'd0) begin
            if (c == CH_STAR) begin
                close_type();
                fr.stars = 2'd1;
            end else begin
                fr.parity = fr.parity ^ c;
                if (fr.tpos != TCI_CLOSED) begin
                    if (c == CH_COMMA) begin
                        close_type();
                    end else if (fr.tpos < TYPE_LEN) begin
                        keep = 8'h00;
                        for (int k = 0; k < NUM_TYPES; k++)
                            if (SENTENCE_IDS[k][39 - 8 * fr.tpos -: 8] == c)
                                keep[k] = 1'b1;
                        fr.types = fr.types & keep;
                        fr.tpos  = fr.tpos + 3'd1;
                    end else begin
                        fr.types = 8'h00;
                        fr.tpos  = TCI_LONG;
                    end
                end
            end
        end else if (c == CH_STAR) begin
            if (fr.stars < 2'd3)
                fr.stars = fr.stars + 2'd1;
        end else if (fr.stars == 2'd1 && fr.hexmode != HX_BAD) begin
            if (c >= "0" && c <= "9")
                d = c - "0";
            else if (c >= "A" && c <= "F")
                d = c - "A" + 10;
            else if (c >= "a" && c <= "f")
                d = c - "a" + 10;
            else
                d = -1;
            if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
                if (fr.hexmode == HX_DIGIT)
                    fr.hexmode = HX_TRAIL;
            end else if (d >= 0 && fr.hexmode <= HX_DIGIT) begin
                fr.hexmode = HX_DIGIT;
                v = fr.hexval * 16 + d;
                fr.hexval = (v > 256) ? HEX_SAT : 9'(v);
            end else begin
                fr.hexmode = HX_BAD;
            end
        end
        v = (fr.hexmode == HX_BAD) ? 0 : fr.hexval;
        if (fr.lead == PH_DOLLAR && fr.length >= MIN_LEN_B && fr.length <= MAX_LEN_B &&
            fr.stars == 2'd1 && v == fr.parity) begin
            r.status       = ST_ACCEPT;
            r.message_type = TYPE_OTHER;
            if (fr.tpos == TCI_CLOSED) begin
                for (int k = NUM_TYPES - 1; k >= 0; k--)
                    if (fr.types[k])
                        r.message_type = 4'(k);
            end
            r.computed_checksum = fr.parity;
            r.sentence_length   = fr.length;
            got = 1'b1;
            fr  = empty_framer();
        end
    endtask

    // Offer one byte, wait for the transaction, then predict
    task automatic push_byte(input logic [7:0] b, input bit pinned, input nsf_result_t want);
        bit          got;
        nsf_result_t r;
        while (!calm && $urandom_range(0, 99) < 20) begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.data_byte <= b;
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
        sent_bytes++;
        frame_byte(b, got, r);
        if (pinned)
            pending.push_back(want);
        else if (got)
            pending.push_back(r);
    endtask

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(8'h20, 8'h7E));
        while (c == CH_DOLLAR || c == CH_STAR);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10)
            return 8'h30 + 8'(d);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
    endfunction

    // Build one sentence, mostly well formed, into burst
    task automatic build_sentence(input int idx);
        int         kind;
        int         sel;
        int         k;
        int         n;
        logic [7:0] sum;
        burst.delete();
        kind = $urandom_range(0, 99);
        if (idx == 5 || idx == 60)
            kind = 99;
        if (kind >= 72 && kind < 80) begin
            repeat ($urandom_range(1, 8))
                burst.push_back(8'($urandom_range(0, 255)));
            return;
        end
        burst.push_back(CH_DOLLAR);
        if (kind >= 88 && kind < 92) begin
            repeat ($urandom_range(0, 3))
                burst.push_back(body_char());
            return;
        end
        k   = $urandom_range(0, 7);
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            for (int i = 0; i < 5; i++)
                burst.push_back(SENTENCE_IDS[k][39 - 8 * i -: 8]);
        end else if (sel == 7) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                burst.push_back(SENTENCE_IDS[k][39 - 8 * i -: 8]);
        end else if (sel == 8) begin
            for (int i = 0; i < 5; i++)
                burst.push_back(SENTENCE_IDS[k][39 - 8 * i -: 8]);
            burst.push_back(body_char());
        end else begin
            repeat ($urandom_range(1, 6))
                burst.push_back(body_char());
        end
        if ($urandom_range(0, 3) != 0)
            burst.push_back(CH_COMMA);
        if (kind >= 92)
            n = (idx == 5) ? 140 : $urandom_range(115, 135);
        else
            n = $urandom_range(0, 12);
        repeat (n)
            burst.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA : body_char());
        sum = 8'h00;
        for (int i = 1; i < burst.size(); i++)
            sum = sum ^ burst[i];
        if (kind >= 60 && kind < 72)
            sum = sum ^ 8'($urandom_range(1, 255));
        burst.push_back(CH_STAR);
        if (kind >= 80 && kind < 88) begin
            sel = $urandom_range(0, 2);
            if (sel == 0)
                burst.push_back(CH_STAR);
            else if (sel == 1)
                burst.push_back(8'($urandom_range(8'h47, 8'h5A)));
            else
                burst.push_back(hex_char(4'($urandom_range(1, 15))));
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2))
                burst.push_back(blank_char());
        if ($urandom_range(0, 5) == 0)
            burst.push_back("0");
        if (sum >= 8'h10 || $urandom_range(0, 1))
            burst.push_back(hex_char(sum[7:4]));
        burst.push_back(hex_char(sum[3:0]));
        if ($urandom_range(0, 9) == 0)
            burst.push_back(blank_char());
    endtask

    initial begin
        int idx;
        int last;
        rst_n           <= 1'b0;
        rx_if.valid     <= 1'b0;
        rx_if.data_byte <= 8'h00;
        fr = empty_framer();

        script.push_back('{"$$", 1'b1, '{ST_MALFORM, TYPE_OTHER, 8'h00, 8'd1}});
        script.push_back('{"A*41", 1'b1, '{ST_ACCEPT, TYPE_OTHER, 8'h41, 8'd5}});
        script.push_back('{"ab$", 1'b1, '{ST_NODOLLAR, TYPE_OTHER, 8'h62, 8'd2}});
        script.push_back('{"GPGGA*56", 1'b1, '{ST_ACCEPT, MT_GPGGA, 8'h56, 8'd9}});
        script.push_back('{"$GPRMC*00$", 1'b1, '{ST_CHECKSUM, TYPE_OTHER, 8'h4B, 8'd9}});
        // empty hex field counts as zero
        script.push_back('{"AAAA*", 1'b1, '{ST_ACCEPT, TYPE_OTHER, 8'h00, 8'd6}});
        // bad hex counts as zero
        script.push_back('{"$AA*G", 1'b1, '{ST_ACCEPT, TYPE_OTHER, 8'h00, 8'd5}});
        script.push_back('{"$A**41$", 1'b1, '{ST_MALFORM, TYPE_OTHER, 8'h41, 8'd6}});
        // hex above 255 never matches
        script.push_back('{"A*141$", 1'b1, '{ST_CHECKSUM, TYPE_OTHER, 8'h41, 8'd6}});
        script.push_back('{"PFLAU,1*\t53", 1'b0, '0});
        script.push_back('{"$PGRMZ,*7e", 1'b0, '0});
        script.push_back('{"$GPGGAX,*22", 1'b0, '0});
        script.push_back('{"\377x*q$", 1'b1, '{ST_NODOLLAR, TYPE_OTHER, 8'h78, 8'd4}});
        script.push_back('{"GPRMC*4B", 1'b1, '{ST_ACCEPT, MT_GPRMC, 8'h4B, 8'd9}});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r]) begin
            last = script[r].text.len() - 1;
            for (int i = 0; i <= last; i++)
                push_byte(script[r].text[i], script[r].pinned && i == last, script[r].want);
        end

        for (idx = 0; sent_bytes < 1650; idx++) begin
            calm = (idx >= 20 && idx < 40);
            if (idx == 50)
                hold_request = 1'b1;
            if (idx == 80) begin
                // hold until every report has drained
                rx_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending.size() != 0);
            end
            build_sentence(idx);
            foreach (burst[i])
                push_byte(burst[i], 1'b0, '0);
        end

        rx_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending.size() != 0);
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("nmea_sentence_framer_unit: match");
        else
            $display("nmea_sentence_framer_unit: mismatch");
        $finish;
    end

    initial begin
        int          hold_left;
        bit          hold_done;
        nsf_result_t w;
        hold_left = 0;
        hold_done = 1'b0;
        res_if.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (pending.size() == 0) begin
                    $error("unexpected report: status %0d, type %0d, checksum %0h, length %0d",
                           res_if.status, res_if.message_type, res_if.computed_checksum,
                           res_if.sentence_length);
                    fault_count++;
                end else begin
                    w = pending.pop_front();
                    if (res_if.status !== w.status) begin
                        $error("status: expected %0d, got %0d", w.status, res_if.status);
                        fault_count++;
                    end
                    if (res_if.message_type !== w.message_type) begin
                        $error("message_type: expected %0d, got %0d",
                               w.message_type, res_if.message_type);
                        fault_count++;
                    end
                    if (res_if.computed_checksum !== w.computed_checksum) begin
                        $error("computed_checksum: expected %0h, got %0h",
                               w.computed_checksum, res_if.computed_checksum);
                        fault_count++;
                    end
                    if (res_if.sentence_length !== w.sentence_length) begin
                        $error("sentence_length: expected %0d, got %0d",
                               w.sentence_length, res_if.sentence_length);
                        fault_count++;
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 200;
            end
            // stall the output long enough for the input to back up
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm || $urandom_range(0, 99) >= 20;
            end
        end
    end

endmodule
